[src/jdcb_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// jdcb_pkg
// Shared types, codes and helpers of the chunk balancer.
// ============================================================================
package jdcb_pkg;

    localparam int QLEN_W     = 10;   // width of one queue length field
    localparam int NUM_QUEUES = 8;    // queue length fields in a request
    localparam int RND_BITS   = 16;   // LFSR width
    localparam int PADDR_W    = 5;    // seven 32-bit registers at 4*i

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_WORKER_COUNT = 3'd0;
    localparam logic [2:0] REG_SELECT_MODE  = 3'd1;
    localparam logic [2:0] REG_CHUNK_MODE   = 3'd2;
    localparam logic [2:0] REG_TOTAL_JOBS   = 3'd3;
    localparam logic [2:0] REG_MAX_CHUNK    = 3'd4;
    localparam logic [2:0] REG_FIXED_CHUNK  = 3'd5;
    localparam logic [2:0] REG_RANDOM_SEED  = 3'd6;

    // register reset values
    localparam logic [3:0]  RST_WORKER_COUNT = 4'd8;
    localparam logic [1:0]  RST_SELECT_MODE  = 2'd0;
    localparam logic [1:0]  RST_CHUNK_MODE   = 2'd0;
    localparam logic [15:0] RST_TOTAL_JOBS   = 16'd1000;
    localparam logic [7:0]  RST_MAX_CHUNK    = 8'd16;
    localparam logic [7:0]  RST_FIXED_CHUNK  = 8'd4;
    localparam logic [15:0] RST_RANDOM_SEED  = 16'd44257;

    // worker selection modes
    localparam logic [1:0] SEL_ROUND_ROBIN = 2'd0;
    localparam logic [1:0] SEL_RANDOM      = 2'd1;
    localparam logic [1:0] SEL_SHORTEST    = 2'd2;

    // chunk sizing modes
    localparam logic [1:0] CHUNK_FIXED  = 2'd0;
    localparam logic [1:0] CHUNK_LINEAR = 2'd1;
    localparam logic [1:0] CHUNK_DOUBLE = 2'd2;

    localparam logic [3:0] ATTEMPT_MAX = 4'd15;

    typedef struct packed {
        logic              start_req;
        logic              accepted;
        logic [QLEN_W-1:0] queue_len_0;
        logic [QLEN_W-1:0] queue_len_1;
        logic [QLEN_W-1:0] queue_len_2;
        logic [QLEN_W-1:0] queue_len_3;
        logic [QLEN_W-1:0] queue_len_4;
        logic [QLEN_W-1:0] queue_len_5;
        logic [QLEN_W-1:0] queue_len_6;
        logic [QLEN_W-1:0] queue_len_7;
    } jdcb_status_t;

    typedef struct packed {
        logic [2:0]  target_worker;
        logic [7:0]  offer_size;
        logic        new_chunk;
        logic [15:0] jobs_left;
        logic        all_done;
    } jdcb_offer_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SIZE,
        ST_PICK,
        ST_EMIT
    } jdcb_state_t;

    typedef enum logic [1:0] {
        ACT_DONE,
        ACT_FRESH,
        ACT_STALE
    } jdcb_action_t;

    typedef struct packed {
        logic                start;
        logic [1:0]          mode;
        logic [3:0]          workers;   // 1..8
        logic [2:0]          last;
        logic [RND_BITS-1:0] rnd;
    } jdcb_pick_cmd_t;

    typedef struct packed {
        logic       done;
        logic [2:0] sel;
    } jdcb_pick_res_t;

    // x^16 + x^14 + x^13 + x^11 + 1, shift right
    function automatic logic [RND_BITS-1:0] lfsr_next(input logic [RND_BITS-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[RND_BITS-1:1]};
    endfunction

endpackage

[src/jdcb_pick.sv]
`timescale 1ns / 1ps
// ============================================================================
// jdcb_pick
// Worker selection unit: one shared subtractor serves a bit-serial modulo
// (random mode) and a linear argmin scan (shortest queue mode).
// ============================================================================
module jdcb_pick
    import jdcb_pkg::*;
#(
    parameter int QW = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  jdcb_pick_cmd_t                cmd,
    input  logic [NUM_QUEUES-1:0][QW-1:0] qlen,
    output jdcb_pick_res_t                res
);

    localparam int UW = (QW > 4) ? QW : 4;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [1:0]          mode_reg, mode_next;
    logic [3:0]          wc_reg, wc_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [UW-1:0]       acc_reg, acc_next;
    logic [2:0]          sel_reg, sel_next;
    logic [RND_BITS-1:0] rnd_reg, rnd_next;

    logic [UW-1:0] op_a, op_b;
    logic [UW:0]   diff;
    logic          borrow;
    logic [3:0]    wc_m1;
    logic [3:0]    prev;

    // shared subtractor: remainder step or queue compare
    always_comb
    begin
        if (mode_reg == SEL_RANDOM)
        begin
            op_a = UW'({acc_reg[2:0], rnd_reg[RND_BITS-1]});
            op_b = UW'(wc_reg);
        end
        else
        begin
            op_a = UW'(qlen[cnt_reg[2:0]]);
            op_b = acc_reg;
        end
        diff   = {1'b0, op_a} - {1'b0, op_b};
        borrow = diff[UW];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        wc_next   = wc_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sel_next  = sel_reg;
        rnd_next  = rnd_reg;
        wc_m1     = cmd.workers - 4'd1;
        prev      = ({1'b0, cmd.last} > wc_m1) ? wc_m1 : {1'b0, cmd.last};

        if (cmd.start)
        begin
            mode_next = cmd.mode;
            wc_next   = cmd.workers;
            rnd_next  = cmd.rnd;
            unique case (cmd.mode)
                SEL_RANDOM:
                begin
                    cnt_next  = 5'(RND_BITS);
                    acc_next  = '0;
                    busy_next = 1'b1;
                end
                SEL_SHORTEST:
                begin
                    cnt_next  = 5'd1;
                    acc_next  = UW'(qlen[0]);
                    sel_next  = 3'd0;
                    busy_next = 1'b1;
                end
                default:
                begin
                    sel_next  = (prev == wc_m1) ? 3'd0 : 3'(prev + 4'd1);
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (mode_reg == SEL_RANDOM)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    sel_next  = acc_reg[2:0];
                end
                else
                begin
                    acc_next = borrow ? op_a : diff[UW-1:0];
                    rnd_next = {rnd_reg[RND_BITS-2:0], 1'b0};
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            else
            begin
                if (cnt_reg >= {1'b0, wc_reg})
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    if (borrow)
                    begin
                        acc_next = op_a;
                        sel_next = cnt_reg[2:0];
                    end
                    cnt_next = cnt_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= SEL_ROUND_ROBIN;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wc_reg  <= wc_next;
        acc_reg <= acc_next;
        sel_reg <= sel_next;
        rnd_reg <= rnd_next;
    end

    assign res.done = done_reg;
    assign res.sel  = sel_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("pick launched while busy");

    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, sel_reg} < wc_reg))
        else $error("selected worker outside worker count");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule

[src/job_dispatch_chunk_balancer_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// job_dispatch_chunk_balancer_core
// Chunk dispatcher: sizes chunks of jobs and offers them to workers chosen by
// round robin, LFSR random or shortest queue.
// ============================================================================
//
//  Channel   Signals                          Carries
//  --------  -------------------------------  ----------------------------------
//  status    status_valid/status_ready/status  start or last offer outcome + queues
//  offer     offer_valid/offer_ready/offer     next offer (worker, size) or done
//  apb       psel/penable/pwrite/paddr/...     seven config registers at 4*i
//
//  Sequence: a request passes UPDATE, SIZE, PICK and EMIT from accept to
//    the next accept; the shortest queue scan walks the workers in PICK and
//    the bit-serial LFSR mod worker_count runs in the shared subtractor of jdcb_pick.
//    A done answer skips PICK.
//  Reset: rst_n async low; registers load their defaults, no jobs remain, so
//    every request other than a start answers done.
//  Stalls: status_ready is high only between requests; a finished offer waits
//    in the output register, and the next request is taken meanwhile.
//
module job_dispatch_chunk_balancer_core
    import jdcb_pkg::*;
#(
    parameter int MAX_WORKERS    = 8,
    parameter int QUEUE_LEN_BITS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // requests
    input  logic               status_valid,
    output logic               status_ready,
    input  jdcb_status_t       status,
    // offers
    output logic               offer_valid,
    input  logic               offer_ready,
    output jdcb_offer_t        offer
);

    // usable workers and compared queue bits
    localparam int EFF_CAP = (MAX_WORKERS < NUM_QUEUES) ? MAX_WORKERS : NUM_QUEUES;
    localparam int QW      = (QUEUE_LEN_BITS < QLEN_W) ? QUEUE_LEN_BITS : QLEN_W;

    // ---------------------------------------------------------------- config
    logic [3:0]  cfg_workers_reg;
    logic [1:0]  cfg_select_reg;
    logic [1:0]  cfg_chunk_reg;
    logic [15:0] cfg_total_reg;
    logic [7:0]  cfg_max_reg;
    logic [7:0]  cfg_fixed_reg;
    logic [15:0] cfg_seed_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_workers_reg <= RST_WORKER_COUNT;
            cfg_select_reg  <= RST_SELECT_MODE;
            cfg_chunk_reg   <= RST_CHUNK_MODE;
            cfg_total_reg   <= RST_TOTAL_JOBS;
            cfg_max_reg     <= RST_MAX_CHUNK;
            cfg_fixed_reg   <= RST_FIXED_CHUNK;
            cfg_seed_reg    <= RST_RANDOM_SEED;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WORKER_COUNT: cfg_workers_reg <= pwdata[3:0];
                REG_SELECT_MODE:  cfg_select_reg  <= pwdata[1:0];
                REG_CHUNK_MODE:   cfg_chunk_reg   <= pwdata[1:0];
                REG_TOTAL_JOBS:   cfg_total_reg   <= pwdata[15:0];
                REG_MAX_CHUNK:    cfg_max_reg     <= pwdata[7:0];
                REG_FIXED_CHUNK:  cfg_fixed_reg   <= pwdata[7:0];
                REG_RANDOM_SEED:  cfg_seed_reg    <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_WORKER_COUNT: prdata = 32'(cfg_workers_reg);
            REG_SELECT_MODE:  prdata = 32'(cfg_select_reg);
            REG_CHUNK_MODE:   prdata = 32'(cfg_chunk_reg);
            REG_TOTAL_JOBS:   prdata = 32'(cfg_total_reg);
            REG_MAX_CHUNK:    prdata = 32'(cfg_max_reg);
            REG_FIXED_CHUNK:  prdata = 32'(cfg_fixed_reg);
            REG_RANDOM_SEED:  prdata = 32'(cfg_seed_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------ run state
    jdcb_state_t   state_reg, state_next;
    jdcb_action_t  action_reg, action_next;
    logic          start_reg, start_next;
    logic          taken_reg, taken_next;
    logic [15:0]   remaining_reg, remaining_next;
    logic [7:0]    chunk_reg, chunk_next;
    logic [2:0]    last_worker_reg, last_worker_next;
    logic [3:0]    attempt_reg, attempt_next;
    logic          batch_ok_reg, batch_ok_next;
    logic          first_chunk_reg, first_chunk_next;
    logic [15:0]   lfsr_state_reg, lfsr_state_next;
    logic          offer_valid_reg, offer_valid_next;
    jdcb_offer_t   offer_reg, offer_next;
    logic [NUM_QUEUES-1:0][QW-1:0] qlen_reg, qlen_next;

    jdcb_pick_cmd_t pick_cmd;
    jdcb_pick_res_t pick_res;

    // worker count: zero means one, clipped to the usable workers
    logic [3:0] eff_workers;
    assign eff_workers = (cfg_workers_reg == 4'd0) ? 4'd1 :
                         (cfg_workers_reg > 4'(EFF_CAP)) ? 4'(EFF_CAP) : cfg_workers_reg;

    // chunk sizing, from the already updated jobs left
    logic [7:0] max_eff;
    logic [8:0] grow;
    logic [7:0] size_clamped;
    logic [7:0] fresh_size;

    always_comb
    begin
        max_eff = (cfg_max_reg == 8'd0) ? 8'd1 : cfg_max_reg;
        if (first_chunk_reg)
            grow = {1'b0, max_eff};
        else if (cfg_chunk_reg == CHUNK_LINEAR)
            grow = batch_ok_reg ? ({1'b0, chunk_reg} + 9'd1)
                 : ((chunk_reg != 8'd0) ? ({1'b0, chunk_reg} - 9'd1) : 9'd0);
        else
            grow = batch_ok_reg ? {chunk_reg, 1'b0} : {2'b00, chunk_reg[7:1]};

        unique case (cfg_chunk_reg)
            CHUNK_LINEAR, CHUNK_DOUBLE:
            begin
                if (grow == 9'd0)
                    size_clamped = 8'd1;
                else if (grow > {1'b0, max_eff})
                    size_clamped = max_eff;
                else
                    size_clamped = grow[7:0];
            end
            default:
                size_clamped = (cfg_fixed_reg == 8'd0) ? 8'd1 : cfg_fixed_reg;
        endcase

        fresh_size = ({8'd0, size_clamped} > remaining_reg) ? remaining_reg[7:0]
                                                             : size_clamped;
    end

    // pick unit launch
    assign pick_cmd.start   = (state_reg == ST_SIZE) && (action_reg != ACT_DONE);
    assign pick_cmd.mode    = cfg_select_reg;
    assign pick_cmd.workers = eff_workers;
    assign pick_cmd.last    = last_worker_reg;
    assign pick_cmd.rnd     = lfsr_next(lfsr_state_reg);

    jdcb_pick #(
        .QW (QW)
    ) u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pick_cmd),
        .qlen  (qlen_reg),
        .res   (pick_res)
    );

    // --------------------------------------------------------------- sequencer
    logic [15:0] used_jobs;
    assign used_jobs = ({8'd0, chunk_reg} > remaining_reg) ? remaining_reg
                                                            : {8'd0, chunk_reg};

    always_comb
    begin
        state_next       = state_reg;
        action_next      = action_reg;
        start_next       = start_reg;
        taken_next       = taken_reg;
        remaining_next   = remaining_reg;
        chunk_next       = chunk_reg;
        last_worker_next = last_worker_reg;
        attempt_next     = attempt_reg;
        batch_ok_next    = batch_ok_reg;
        first_chunk_next = first_chunk_reg;
        lfsr_state_next  = lfsr_state_reg;
        qlen_next        = qlen_reg;
        offer_next       = offer_reg;
        offer_valid_next = offer_valid_reg && !offer_ready;
        status_ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                status_ready = 1'b1;
                if (status_valid)
                begin
                    start_next   = status.start_req;
                    taken_next   = status.accepted;
                    qlen_next[0] = status.queue_len_0[QW-1:0];
                    qlen_next[1] = status.queue_len_1[QW-1:0];
                    qlen_next[2] = status.queue_len_2[QW-1:0];
                    qlen_next[3] = status.queue_len_3[QW-1:0];
                    qlen_next[4] = status.queue_len_4[QW-1:0];
                    qlen_next[5] = status.queue_len_5[QW-1:0];
                    qlen_next[6] = status.queue_len_6[QW-1:0];
                    qlen_next[7] = status.queue_len_7[QW-1:0];
                    state_next   = ST_UPDATE;
                end
            end

            // apply the outcome of the last offer, decide what comes next
            ST_UPDATE:
            begin
                if (start_reg)
                begin
                    remaining_next   = cfg_total_reg;
                    lfsr_state_next  = (cfg_seed_reg == 16'd0) ? 16'd1 : cfg_seed_reg;
                    first_chunk_next = 1'b1;
                    batch_ok_next    = 1'b0;
                    last_worker_next = 3'd0;
                    attempt_next     = 4'd0;
                    chunk_next       = 8'd0;
                    action_next      = (cfg_total_reg == 16'd0) ? ACT_DONE : ACT_FRESH;
                end
                else if (remaining_reg == 16'd0)
                    action_next = ACT_DONE;
                else if (taken_reg)
                begin
                    remaining_next = remaining_reg - used_jobs;
                    batch_ok_next  = 1'b1;
                    action_next    = ({8'd0, chunk_reg} >= remaining_reg) ? ACT_DONE
                                                                          : ACT_FRESH;
                end
                else if (attempt_reg >= eff_workers)
                begin
                    // every worker refused: resize as after a failed batch (smaller in linear and doubling modes)
                    batch_ok_next = 1'b0;
                    action_next   = ACT_FRESH;
                end
                else
                    action_next = ACT_STALE;
                state_next = ST_UPDATE == state_reg ? ST_SIZE : state_reg;
            end

            ST_SIZE:
            begin
                if (action_reg == ACT_DONE)
                    state_next = ST_EMIT;
                else
                begin
                    if (action_reg == ACT_FRESH)
                    begin
                        chunk_next       = fresh_size;
                        first_chunk_next = 1'b0;
                        attempt_next     = 4'd0;
                    end
                    if (cfg_select_reg == SEL_RANDOM)
                        lfsr_state_next = pick_cmd.rnd;
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                if (pick_res.done)
                begin
                    last_worker_next = pick_res.sel;
                    if (attempt_reg != ATTEMPT_MAX)
                        attempt_next = attempt_reg + 4'd1;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!offer_valid_reg || offer_ready)
                begin
                    if (action_reg == ACT_DONE)
                    begin
                        offer_next          = '0;
                        offer_next.all_done = 1'b1;
                    end
                    else
                    begin
                        offer_next.target_worker = last_worker_reg;
                        offer_next.offer_size    = chunk_reg;
                        offer_next.new_chunk     = (action_reg == ACT_FRESH);
                        offer_next.jobs_left     = remaining_reg;
                        offer_next.all_done      = 1'b0;
                    end
                    offer_valid_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            action_reg      <= ACT_DONE;
            start_reg       <= 1'b0;
            taken_reg       <= 1'b0;
            remaining_reg   <= '0;
            chunk_reg       <= '0;
            last_worker_reg <= '0;
            attempt_reg     <= '0;
            batch_ok_reg    <= 1'b0;
            first_chunk_reg <= 1'b1;
            lfsr_state_reg  <= RST_RANDOM_SEED;
            offer_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            action_reg      <= action_next;
            start_reg       <= start_next;
            taken_reg       <= taken_next;
            remaining_reg   <= remaining_next;
            chunk_reg       <= chunk_next;
            last_worker_reg <= last_worker_next;
            attempt_reg     <= attempt_next;
            batch_ok_reg    <= batch_ok_next;
            first_chunk_reg <= first_chunk_next;
            lfsr_state_reg  <= lfsr_state_next;
            offer_valid_reg <= offer_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qlen_reg  <= qlen_next;
        offer_reg <= offer_next;
    end

    assign offer_valid = offer_valid_reg;
    assign offer       = offer_reg;

    // -------------------------------------------------------------- checks
    a_done_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        offer_valid && offer.all_done |->
            offer.offer_size == 8'd0 && offer.jobs_left == 16'd0 && !offer.new_chunk)
        else $error("done offer carries payload");

    a_offer_size_ok: assert property (@(posedge clk) disable iff (!rst_n)
        offer_valid && !offer.all_done |->
            offer.offer_size != 8'd0 && {8'd0, offer.offer_size} <= offer.jobs_left)
        else $error("offer size zero or above jobs left");

    a_worker_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        offer_valid && !offer.all_done |-> {1'b0, offer.target_worker} < eff_workers)
        else $error("offer targets a worker outside the count");

endmodule

[tb/tb_job_dispatch_chunk_balancer_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_job_dispatch_chunk_balancer_core
// Self-checking bench for the chunk balancer: a directed table, then random
// runs under random register settings, with random stalls on both sides.
// Every offer is checked field by field against a local dispatcher model or a typed row.
// ============================================================================
module tb_job_dispatch_chunk_balancer_core;
    import jdcb_pkg::*;

    localparam int IDLE_PCT      = 12;         // share of idle cycles per side
    localparam int SETTLE_CYCLES = 40;         // room for the slowest request to finish
    localparam int RANDOM_ITEMS  = 1000;
    localparam int DIRECTED_ROWS = 25;
    localparam int RUN_LIMIT_NS  = 5_000_000;  // far above the slowest pass

    // mode codes the package leaves unnamed
    localparam logic [1:0] SEL_UNUSED   = 2'd3;
    localparam logic [1:0] CHUNK_UNUSED = 2'd3;

    // one full set of register values
    typedef struct packed {
        logic [3:0]  wc;
        logic [1:0]  sel;
        logic [1:0]  cmode;
        logic [15:0] total;
        logic [7:0]  maxc;
        logic [7:0]  fixc;
        logic [15:0] seed;
    } dispatch_cfg_t;

    // one row of the directed table; queues are q_fill except one worker
    typedef struct packed {
        logic          load_cfg;
        dispatch_cfg_t cfg;
        logic          start_req;
        logic          accepted;
        logic [9:0]    q_fill;
        logic [2:0]    q_pick_idx;
        logic [9:0]    q_pick_val;
        logic          typed;
        jdcb_offer_t   want;
    } directed_row_t;

    localparam jdcb_offer_t   DONE_OFFER = '{3'd0, 8'd0, 1'b0, 16'd0, 1'b1};
    localparam dispatch_cfg_t KEEP_CFG   = '0;

    // directed register sets
    localparam dispatch_cfg_t CFG_LINEAR_TWO =
        '{4'd2, SEL_ROUND_ROBIN, CHUNK_LINEAR, 16'd20, 8'd8, 8'd0, 16'd0};
    localparam dispatch_cfg_t CFG_DOUBLE_MAX =
        '{4'd8, SEL_SHORTEST, CHUNK_DOUBLE, 16'd65535, 8'd255, 8'd1, 16'd1};
    localparam dispatch_cfg_t CFG_ONE_WORKER =
        '{4'd1, SEL_SHORTEST, CHUNK_DOUBLE, 16'd65535, 8'd255, 8'd1, 16'd1};
    localparam dispatch_cfg_t CFG_ALL_ZERO =
        '{4'd0, SEL_RANDOM, CHUNK_UNUSED, 16'd0, 8'd0, 8'd0, 16'd0};
    localparam dispatch_cfg_t CFG_OVERSIZE =
        '{4'd15, SEL_RANDOM, CHUNK_LINEAR, 16'd3, 8'd0, 8'd255, 16'd0};
    localparam dispatch_cfg_t CFG_UNCLAMPED =
        '{4'd5, SEL_UNUSED, CHUNK_FIXED, 16'd600, 8'd1, 8'd255, 16'd65535};

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               status_valid = 1'b0;
    logic               status_ready;
    jdcb_status_t       status       = '0;
    logic               offer_valid;
    logic               offer_ready  = 1'b0;
    jdcb_offer_t        offer;

    job_dispatch_chunk_balancer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .status_valid (status_valid),
        .status_ready (status_ready),
        .status       (status),
        .offer_valid  (offer_valid),
        .offer_ready  (offer_ready),
        .offer        (offer)
    );

    // ------------------------------------------------------------------------
    // Dispatcher model: register copy plus run state, reset values as the
    // block comes out of reset.
    // ------------------------------------------------------------------------
    dispatch_cfg_t shadow_cfg   = '{RST_WORKER_COUNT, RST_SELECT_MODE, RST_CHUNK_MODE,
                                    RST_TOTAL_JOBS, RST_MAX_CHUNK, RST_FIXED_CHUNK,
                                    RST_RANDOM_SEED};
    logic [15:0]   jobs_pending = '0;
    logic [7:0]    live_chunk   = '0;
    logic [2:0]    prev_worker  = '0;
    logic [3:0]    tries        = '0;
    logic          last_ok      = 1'b0;
    logic          sizing_first = 1'b1;
    logic [15:0]   lfsr_q       = RST_RANDOM_SEED;

    jdcb_offer_t   expected_offers [$];
    jdcb_offer_t   want_offer;
    directed_row_t plan [DIRECTED_ROWS];

    int  errors         = 0;
    int  offers_checked = 0;
    int  done_answers   = 0;
    bit  no_idle        = 1'b0;

    // zero workers act as one, more than the queue inputs are cut
    function automatic int unsigned workers_in_use();
        int unsigned w;
        w = shadow_cfg.wc;
        if (w == 0)
            w = 1;
        if (w > NUM_QUEUES)
            w = NUM_QUEUES;
        return w;
    endfunction

    // sizes a chunk when fresh, then picks the worker for this offer
    function automatic jdcb_offer_t build_offer(input jdcb_status_t s, input logic fresh);
        jdcb_offer_t                        o;
        logic [0:NUM_QUEUES-1][QLEN_W-1:0] qs;
        int unsigned                        mx;
        int unsigned                        c;
        int unsigned                        cur;
        int unsigned                        wc;
        int unsigned                        sel;
        int unsigned                        prev;
        int unsigned                        best;
        logic                               fb;
        qs  = {s.queue_len_0, s.queue_len_1, s.queue_len_2, s.queue_len_3,
               s.queue_len_4, s.queue_len_5, s.queue_len_6, s.queue_len_7};
        wc  = workers_in_use();
        cur = live_chunk;
        if (fresh)
        begin
            mx = (shadow_cfg.maxc != 0) ? shadow_cfg.maxc : 1;
            if (shadow_cfg.cmode == CHUNK_LINEAR || shadow_cfg.cmode == CHUNK_DOUBLE)
            begin
                if (sizing_first)
                    c = mx;
                else if (shadow_cfg.cmode == CHUNK_LINEAR)
                    c = last_ok ? cur + 1 : ((cur != 0) ? cur - 1 : 0);
                else
                    c = last_ok ? cur * 2 : cur / 2;
                if (c == 0)
                    c = 1;
                if (c > mx)
                    c = mx;
            end
            else
            begin
                // constant and unused mode: no max clamp
                c = (shadow_cfg.fixc != 0) ? shadow_cfg.fixc : 1;
            end
            if (c > jobs_pending)
                c = jobs_pending;
            sizing_first = 1'b0;
            live_chunk   = 8'(c);
            tries        = '0;
        end
        if (shadow_cfg.sel == SEL_RANDOM)
        begin
            fb     = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
            lfsr_q = {fb, lfsr_q[15:1]};
            sel    = lfsr_q % wc;
        end
        else if (shadow_cfg.sel == SEL_SHORTEST)
        begin
            // first worker with the strictly smallest queue
            sel  = 0;
            best = qs[0];
            for (int i = 1; i < wc; i++)
            begin
                if (qs[i] < best)
                begin
                    best = qs[i];
                    sel  = i;
                end
            end
        end
        else
        begin
            prev = prev_worker;
            if (prev > wc - 1)
                prev = wc - 1;
            sel = (prev == wc - 1) ? 0 : prev + 1;
        end
        prev_worker = 3'(sel);
        if (tries < ATTEMPT_MAX)
            tries = tries + 4'd1;
        o.target_worker = prev_worker;
        o.offer_size    = live_chunk;
        o.new_chunk     = fresh;
        o.jobs_left     = jobs_pending;
        o.all_done      = 1'b0;
        return o;
    endfunction

    function automatic jdcb_offer_t predict_offer(input jdcb_status_t s);
        if (s.start_req)
        begin
            // a start drops any run in progress; accepted is ignored
            jobs_pending = shadow_cfg.total;
            lfsr_q       = (shadow_cfg.seed != 0) ? shadow_cfg.seed : 16'd1;
            sizing_first = 1'b1;
            last_ok      = 1'b0;
            prev_worker  = '0;
            tries        = '0;
            live_chunk   = '0;
            if (jobs_pending == 0)
                return DONE_OFFER;
            return build_offer(s, 1'b1);
        end
        if (jobs_pending == 0)
            return DONE_OFFER;
        if (s.accepted)
        begin
            if (live_chunk > jobs_pending)
                jobs_pending = '0;
            else
                jobs_pending = jobs_pending - live_chunk;
            last_ok = 1'b1;
            if (jobs_pending == 0)
                return DONE_OFFER;
            return build_offer(s, 1'b1);
        end
        // refused: re-offer until the chunk has been tried on enough workers
        if (tries >= workers_in_use())
        begin
            last_ok = 1'b0;
            return build_offer(s, 1'b1);
        end
        return build_offer(s, 1'b0);
    endfunction

    // ------------------------------------------------------------------------
    // Bus side. Inputs change only by nonblocking assignment at the rising
    // edge; handshake signals are read right after the edge, before the
    // block's own updates land.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // APB write: setup, then access; the next write may follow directly
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic apply_config(input dispatch_cfg_t c);
        write_reg(REG_WORKER_COUNT, 32'(c.wc));
        write_reg(REG_SELECT_MODE,  32'(c.sel));
        write_reg(REG_CHUNK_MODE,   32'(c.cmode));
        write_reg(REG_TOTAL_JOBS,   32'(c.total));
        write_reg(REG_MAX_CHUNK,    32'(c.maxc));
        write_reg(REG_FIXED_CHUNK,  32'(c.fixc));
        write_reg(REG_RANDOM_SEED,  32'(c.seed));
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        shadow_cfg  = c;
        @(posedge clk);
    endtask

    // drop valid, let every offer come back, then let the block settle
    task automatic wait_idle();
        status_valid <= 1'b0;
        while (expected_offers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one request; a typed expectation replaces the model's, but the model
    // still steps so its state stays in line with the block
    task automatic send_status(input jdcb_status_t s, input logic typed,
                               input jdcb_offer_t want);
        jdcb_offer_t predicted;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            status_valid <= 1'b0;
            @(posedge clk);
        end
        status_valid <= 1'b1;
        status       <= s;
        @(posedge clk);
        while (!status_ready)
            @(posedge clk);
        predicted = predict_offer(s);
        expected_offers.push_back(typed ? want : predicted);
    endtask

    // offer side stalls at random, except during the no-idle stretch
    always @(posedge clk)
        offer_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // every accepted offer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && offer_valid && offer_ready)
        begin
            if (expected_offers.size() == 0)
            begin
                errors++;
                $display("%0t: offer %h with nothing expected: expected none, got %h",
                         $time, offer, offer);
            end
            else
            begin
                want_offer = expected_offers.pop_front();
                check_field("target_worker", want_offer.target_worker, offer.target_worker);
                check_field("offer_size",    want_offer.offer_size,    offer.offer_size);
                check_field("new_chunk",     want_offer.new_chunk,     offer.new_chunk);
                check_field("jobs_left",     want_offer.jobs_left,     offer.jobs_left);
                check_field("all_done",      want_offer.all_done,      offer.all_done);
                offers_checked++;
                if (offer.all_done)
                    done_answers++;
            end
        end
    end

    // hard stop if the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_job_dispatch_chunk_balancer_core NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        jdcb_status_t                        s;
        logic [0:NUM_QUEUES-1][QLEN_W-1:0]   qvec;
        dispatch_cfg_t                       c;
        directed_row_t                       r;
        int                                  random_items;
        int                                  phases;
        int                                  n;
        int                                  pick;

        // Directed table. Typed rows: idle after reset, the default run,
        // finishing runs, the largest first chunk, an empty start, and a
        // constant chunk above max_chunk. The rest go through the model.
        //              load  cfg             st    acc   fill    idx   val
        plan[0]  = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd0,    3'd0, 10'd0,
                     1'b1, DONE_OFFER};                                 // idle: done
        plan[1]  = '{1'b0, KEEP_CFG,       1'b1, 1'b0, 10'd7,    3'd0, 10'd7,
                     1'b1, '{3'd1, 8'd4, 1'b1, 16'd1000, 1'b0}};        // default run
        plan[2]  = '{1'b0, KEEP_CFG,       1'b0, 1'b0, 10'd7,    3'd0, 10'd7,
                     1'b1, '{3'd2, 8'd4, 1'b0, 16'd1000, 1'b0}};        // refused
        plan[3]  = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd7,    3'd0, 10'd7,
                     1'b1, '{3'd3, 8'd4, 1'b1, 16'd996, 1'b0}};         // taken
        // linear sizing on two workers, zero fixed chunk and zero seed
        plan[4]  = '{1'b1, CFG_LINEAR_TWO, 1'b1, 1'b0, 10'd1,    3'd1, 10'd2,
                     1'b0, '0};
        plan[5]  = '{1'b0, KEEP_CFG,       1'b0, 1'b0, 10'd3,    3'd0, 10'd9,
                     1'b0, '0};
        plan[6]  = '{1'b0, KEEP_CFG,       1'b0, 1'b0, 10'd3,    3'd0, 10'd9,
                     1'b0, '0};                                         // cycle failed
        plan[7]  = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd3,    3'd0, 10'd9,
                     1'b0, '0};
        plan[8]  = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd3,    3'd0, 10'd9,
                     1'b0, '0};                                         // capped by jobs
        plan[9]  = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd3,    3'd0, 10'd9,
                     1'b1, DONE_OFFER};
        plan[10] = '{1'b0, KEEP_CFG,       1'b0, 1'b0, 10'd3,    3'd0, 10'd9,
                     1'b1, DONE_OFFER};                                 // finished
        // doubling, shortest queue, all extremes
        plan[11] = '{1'b1, CFG_DOUBLE_MAX, 1'b1, 1'b0, 10'd1023, 3'd7, 10'd0,
                     1'b1, '{3'd7, 8'd255, 1'b1, 16'd65535, 1'b0}};
        plan[12] = '{1'b0, KEEP_CFG,       1'b0, 1'b0, 10'd0,    3'd0, 10'd0,
                     1'b0, '0};                                         // all tied
        plan[13] = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd5,    3'd0, 10'd5,
                     1'b0, '0};
        plan[14] = '{1'b0, KEEP_CFG,       1'b0, 1'b0, 10'd1023, 3'd3, 10'd1022,
                     1'b0, '0};
        // worker count lowered under a chunk already tried twice
        plan[15] = '{1'b1, CFG_ONE_WORKER, 1'b0, 1'b0, 10'd4,    3'd0, 10'd4,
                     1'b0, '0};
        // zero everywhere: count, chunks, seed, unused chunk mode
        plan[16] = '{1'b1, CFG_ALL_ZERO,   1'b0, 1'b0, 10'd9,    3'd2, 10'd1,
                     1'b0, '0};
        plan[17] = '{1'b0, KEEP_CFG,       1'b1, 1'b1, 10'd9,    3'd2, 10'd1,
                     1'b1, DONE_OFFER};                                 // empty start
        // count above eight, zero max, random pick from seed one
        plan[18] = '{1'b1, CFG_OVERSIZE,   1'b1, 1'b0, 10'd512,  3'd4, 10'd511,
                     1'b0, '0};
        plan[19] = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd512,  3'd4, 10'd511,
                     1'b0, '0};
        plan[20] = '{1'b0, KEEP_CFG,       1'b1, 1'b1, 10'd512,  3'd4, 10'd511,
                     1'b0, '0};                                         // restart
        // unused select mode, constant chunk above max_chunk
        plan[21] = '{1'b1, CFG_UNCLAMPED,  1'b1, 1'b0, 10'd8,    3'd0, 10'd8,
                     1'b1, '{3'd1, 8'd255, 1'b1, 16'd600, 1'b0}};
        plan[22] = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd8,    3'd0, 10'd8,
                     1'b0, '0};
        plan[23] = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd8,    3'd0, 10'd8,
                     1'b0, '0};
        plan[24] = '{1'b0, KEEP_CFG,       1'b0, 1'b1, 10'd8,    3'd0, 10'd8,
                     1'b1, DONE_OFFER};

        random_items = 0;
        phases       = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            r = plan[i];
            if (r.load_cfg)
            begin
                wait_idle();
                apply_config(r.cfg);
            end
            qvec               = {NUM_QUEUES{r.q_fill}};
            qvec[r.q_pick_idx] = r.q_pick_val;
            s                  = {r.start_req, r.accepted, qvec};
            send_status(s, r.typed, r.want);
        end

        // Random phases: new settings, usually a start, then a run of
        // outcomes. Mostly small totals so runs end and restart often.
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            pick    = $urandom_range(0, 9);
            c.wc    = (pick < 8) ? 4'($urandom_range(1, 8)) : 4'($urandom);
            c.sel   = 2'($urandom_range(0, 3));
            c.cmode = 2'($urandom_range(0, 3));
            pick    = $urandom_range(0, 9);
            c.total = (pick < 7) ? 16'($urandom_range(1, 300)) :
                      (pick == 7) ? 16'd0 : (pick == 8) ? 16'hFFFF : 16'($urandom);
            pick    = $urandom_range(0, 9);
            c.maxc  = (pick < 7) ? 8'($urandom_range(1, 32)) :
                      (pick == 7) ? 8'd0 : (pick == 8) ? 8'hFF : 8'($urandom);
            pick    = $urandom_range(0, 9);
            c.fixc  = (pick < 7) ? 8'($urandom_range(1, 32)) :
                      (pick == 7) ? 8'd0 : (pick == 8) ? 8'hFF : 8'($urandom);
            pick    = $urandom_range(0, 9);
            c.seed  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            apply_config(c);
            phases++;

            // without a start the run left by the last phase goes on
            n = $urandom_range(8, 60);
            for (int k = 0; k < n; k++)
            begin
                for (int q = 0; q < NUM_QUEUES; q++)
                    qvec[q] = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 3))
                                                           : 10'($urandom);
                s = {1'b0, ($urandom_range(0, 99) < 55), qvec};
                if (k == 0)
                    s.start_req = ($urandom_range(0, 9) < 8);
                else if (jobs_pending == 0)
                    s.start_req = ($urandom_range(0, 9) < 7);
                else
                    s.start_req = ($urandom_range(0, 99) < 3);
                random_items++;
                no_idle = (random_items >= 400 && random_items < 600);
                send_status(s, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        wait_idle();
        $display("covered %0d directed rows and %0d random requests over %0d settings",
                 DIRECTED_ROWS, random_items, phases);
        $display("checked %0d offers, %0d of them done answers, %0d mismatches",
                 offers_checked, done_answers, errors);
        if (errors == 0)
            $display("tb_job_dispatch_chunk_balancer_core OK");
        else
            $display("tb_job_dispatch_chunk_balancer_core NOT OK");
        $finish;
    end

endmodule

[files.f]
src/jdcb_pkg.sv
src/jdcb_pick.sv
src/job_dispatch_chunk_balancer_core.sv
tb/tb_job_dispatch_chunk_balancer_core.sv
